/* src/rht_pkg.sv */
`default_nettype none

package rht_pkg;

    localparam int KEY_W = 32;
    localparam int COUNT_W = 16;
    localparam int HANDLE_W = 4;
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    typedef enum logic {
        CMD_ACQUIRE = 1'b0,
        CMD_RELEASE = 1'b1
    } t_cmd;

    typedef enum logic [2:0] {
        ST_NEW    = 3'd0,
        ST_SHARED = 3'd1,
        ST_FULL   = 3'd2,
        ST_NULL   = 3'd3,
        ST_HELD   = 3'd4,
        ST_FREED  = 3'd5,
        ST_RANGE  = 3'd6,
        ST_STALE  = 3'd7
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_RELRD,
        S_DONE
    } t_state;

    // Results of the shared compare and count unit for one table word.
    typedef struct packed {
        logic               key_eq;
        logic               count_gt1;
        logic [COUNT_W-1:0] count_inc;
        logic [COUNT_W-1:0] count_dec;
    } t_unit_res;

endpackage

`default_nettype wire

/* src/rht_ram.sv */
`default_nettype none

module rht_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

/* src/rht_unit.sv */
`default_nettype none

module rht_unit (
    input  wire logic [rht_pkg::KEY_W-1:0]   i_key_a,
    input  wire logic [rht_pkg::KEY_W-1:0]   i_key_b,
    input  wire logic [rht_pkg::COUNT_W-1:0] i_count,
    output rht_pkg::t_unit_res               o_res
);

    always_comb begin
        o_res.key_eq    = (i_key_a == i_key_b);
        o_res.count_gt1 = (i_count > rht_pkg::COUNT_W'(1));
        // The count sticks at its maximum instead of wrapping.
        o_res.count_inc = (i_count == rht_pkg::COUNT_MAX) ? rht_pkg::COUNT_MAX
                                                          : i_count + rht_pkg::COUNT_W'(1);
        o_res.count_dec = i_count - rht_pkg::COUNT_W'(1);
    end

endmodule

`default_nettype wire

/* src/refcounted_handle_table.sv */
// Reference-counted handle table.
// Input stream: tuser carries the command (0 acquire, 1 release); tdata carries the
// object key in bits 31:0 and the handle to release in bits 39:32.
// Output stream: tdata carries the handle in bits 3:0 and the reference count in
// bits 19:4; tuser carries the status code (new, shared, full, null key, still
// referenced, freed, out of range, stale).
// Every input transaction produces exactly one output transaction, in order.
// An acquire of a nonzero key scans the table one slot per cycle through the
// single read port of the key/count RAM; a matching key ends the scan early. A
// release reads the slot and then writes back its count; a null key or an
// out-of-range or stale handle goes straight to its result.
// s_axis_tready is high only while no transaction is in progress, so the block
// takes no new item until the last one has finished.
// A finished result waits in the output register while the next transaction is
// accepted; if the receiver stalls, the following result holds in the sequencer
// until the output register is free.
// Reset clears the in-use bits, so every slot is free; the RAM itself is not
// cleared and needs no clearing pass.
`default_nettype none

module refcounted_handle_table #(
    parameter int SLOTS = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [39:0] i_s_axis_tdata,   // object_key [31:0], release_handle [39:32]
    input  wire logic        i_s_axis_tuser,   // cmd [0]
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic      [23:0] o_m_axis_tdata,   // handle_out [3:0], ref_count [19:4], zero pad
    output logic      [2:0]  o_m_axis_tuser    // status [2:0]
);

    localparam int IDX_W = $clog2(SLOTS);
    localparam int CNT_W = $clog2(SLOTS + 1);
    localparam int SW = (IDX_W > rht_pkg::HANDLE_W) ? IDX_W : rht_pkg::HANDLE_W;
    localparam int KW = rht_pkg::KEY_W;
    localparam int CW = rht_pkg::COUNT_W;
    localparam int WORD_W = KW + CW;
    localparam logic [CNT_W-1:0] SLOTS_C = CNT_W'(SLOTS);
    localparam logic [8:0] SLOTS_9 = 9'(SLOTS);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

    rht_pkg::t_state  r_state, n_state;
    rht_pkg::t_cmd    r_cmd, n_cmd;
    logic [KW-1:0]    r_key, n_key;
    logic [IDX_W-1:0] r_hdl, n_hdl;
    logic [CNT_W-1:0] r_idx, n_idx;
    logic             r_cmp_vld, n_cmp_vld;
    logic [IDX_W-1:0] r_cmp_idx, n_cmp_idx;
    logic             r_free_vld, n_free_vld;
    logic [IDX_W-1:0] r_free_idx, n_free_idx;
    logic [SLOTS-1:0] r_used, n_used;

    logic [IDX_W-1:0]  r_res_slot, n_res_slot;
    rht_pkg::t_status  r_res_status, n_res_status;
    logic [CW-1:0]     r_res_count, n_res_count;

    logic              r_out_vld, n_out_vld;
    logic [IDX_W-1:0]  r_out_slot, n_out_slot;
    rht_pkg::t_status  r_out_status, n_out_status;
    logic [CW-1:0]     r_out_count, n_out_count;

    logic              in_fire;
    rht_pkg::t_cmd     in_cmd;
    logic [KW-1:0]     in_key;
    logic [7:0]        in_hdl;
    logic              in_range_err;
    logic [IDX_W-1:0]  in_idx;

    logic              w_we;
    logic [IDX_W-1:0]  w_waddr;
    logic [WORD_W-1:0] w_wdata;
    logic [IDX_W-1:0]  w_raddr;
    logic [WORD_W-1:0] w_rdata;
    logic [KW-1:0]     rd_key;
    logic [CW-1:0]     rd_count;
    rht_pkg::t_unit_res w_unit;

    logic              hit;
    logic              cmp_free;
    logic              scan_last;
    logic              free_any;
    logic [IDX_W-1:0]  free_slot;
    logic              out_free;
    logic [SW-1:0]     slot_wide;

    assign in_fire      = i_s_axis_tvalid && o_s_axis_tready;
    assign in_cmd       = rht_pkg::t_cmd'(i_s_axis_tuser);
    assign in_key       = i_s_axis_tdata[31:0];
    assign in_hdl       = i_s_axis_tdata[39:32];
    assign in_range_err = ({1'b0, in_hdl} >= SLOTS_9);
    assign in_idx       = in_hdl[IDX_W-1:0];

    assign w_raddr  = (r_state == rht_pkg::S_IDLE) ? in_idx : r_idx[IDX_W-1:0];
    assign rd_key   = w_rdata[KW-1:0];
    assign rd_count = w_rdata[WORD_W-1:KW];

    // The first free slot seen during the scan is kept for a new key.
    assign hit       = r_cmp_vld && r_used[r_cmp_idx] && w_unit.key_eq;
    assign cmp_free  = r_cmp_vld && !r_used[r_cmp_idx];
    assign scan_last = r_cmp_vld && (r_cmp_idx == LAST_IDX);
    assign free_any  = r_free_vld || cmp_free;
    assign free_slot = r_free_vld ? r_free_idx : r_cmp_idx;
    assign out_free  = !r_out_vld || i_m_axis_tready;

    rht_ram #(
        .WIDTH(WORD_W),
        .DEPTH(SLOTS)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(w_waddr),
        .i_wdata(w_wdata),
        .i_raddr(w_raddr),
        .o_rdata(w_rdata)
    );

    rht_unit u_unit (
        .i_key_a(r_key),
        .i_key_b(rd_key),
        .i_count(rd_count),
        .o_res  (w_unit)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            rht_pkg::S_IDLE: begin
                if (in_fire) begin
                    if (in_cmd == rht_pkg::CMD_ACQUIRE) begin
                        n_state = (in_key == '0) ? rht_pkg::S_DONE : rht_pkg::S_SCAN;
                    end else if (in_range_err || !r_used[in_idx]) begin
                        n_state = rht_pkg::S_DONE;
                    end else begin
                        n_state = rht_pkg::S_RELRD;
                    end
                end
            end
            rht_pkg::S_SCAN: begin
                if (hit || scan_last) begin
                    n_state = rht_pkg::S_DONE;
                end
            end
            rht_pkg::S_RELRD: begin
                n_state = rht_pkg::S_DONE;
            end
            rht_pkg::S_DONE: begin
                if (out_free) begin
                    n_state = rht_pkg::S_IDLE;
                end
            end
            default: n_state = rht_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_s_axis_tready = (r_state == rht_pkg::S_IDLE);
        n_cmd        = r_cmd;
        n_key        = r_key;
        n_hdl        = r_hdl;
        n_idx        = r_idx;
        n_cmp_vld    = r_cmp_vld;
        n_cmp_idx    = r_cmp_idx;
        n_free_vld   = r_free_vld;
        n_free_idx   = r_free_idx;
        n_used       = r_used;
        n_res_slot   = r_res_slot;
        n_res_status = r_res_status;
        n_res_count  = r_res_count;
        n_out_vld    = r_out_vld && !i_m_axis_tready;
        n_out_slot   = r_out_slot;
        n_out_status = r_out_status;
        n_out_count  = r_out_count;
        w_we         = 1'b0;
        w_waddr      = r_hdl;
        w_wdata      = {rd_count, rd_key};

        unique case (r_state)
            rht_pkg::S_IDLE: begin
                if (in_fire) begin
                    n_cmd        = in_cmd;
                    n_key        = in_key;
                    n_hdl        = in_idx;
                    n_idx        = '0;
                    n_cmp_vld    = 1'b0;
                    n_free_vld   = 1'b0;
                    n_res_slot   = '0;
                    n_res_count  = '0;
                    n_res_status = rht_pkg::ST_NULL;
                    if (in_cmd == rht_pkg::CMD_RELEASE) begin
                        priority if (in_range_err) begin
                            n_res_status = rht_pkg::ST_RANGE;
                        end else if (!r_used[in_idx]) begin
                            n_res_status = rht_pkg::ST_STALE;
                        end else begin
                            n_res_status = rht_pkg::ST_FREED;
                        end
                    end
                end
            end
            rht_pkg::S_SCAN: begin
                // A match ends the scan, so no compare is left pending behind it.
                n_cmp_vld = (r_idx < SLOTS_C) && !hit;
                n_cmp_idx = r_idx[IDX_W-1:0];
                if (r_idx < SLOTS_C) begin
                    n_idx = r_idx + CNT_W'(1);
                end
                if (cmp_free && !r_free_vld) begin
                    n_free_vld = 1'b1;
                    n_free_idx = r_cmp_idx;
                end
                priority if (hit) begin
                    w_we         = 1'b1;
                    w_waddr      = r_cmp_idx;
                    w_wdata      = {w_unit.count_inc, r_key};
                    n_res_slot   = r_cmp_idx;
                    n_res_status = rht_pkg::ST_SHARED;
                    n_res_count  = w_unit.count_inc;
                end else if (scan_last) begin
                    if (free_any) begin
                        w_we              = 1'b1;
                        w_waddr           = free_slot;
                        w_wdata           = {CW'(1), r_key};
                        n_used[free_slot] = 1'b1;
                        n_res_slot        = free_slot;
                        n_res_status      = rht_pkg::ST_NEW;
                        n_res_count       = CW'(1);
                    end else begin
                        n_res_slot   = '0;
                        n_res_status = rht_pkg::ST_FULL;
                        n_res_count  = '0;
                    end
                end else begin
                    n_res_slot = r_res_slot;
                end
            end
            rht_pkg::S_RELRD: begin
                w_we       = 1'b1;
                w_waddr    = r_hdl;
                n_res_slot = r_hdl;
                if (w_unit.count_gt1) begin
                    w_wdata      = {w_unit.count_dec, rd_key};
                    n_res_status = rht_pkg::ST_HELD;
                    n_res_count  = w_unit.count_dec;
                end else begin
                    w_wdata       = {CW'(0), rd_key};
                    n_used[r_hdl] = 1'b0;
                    n_res_status  = rht_pkg::ST_FREED;
                    n_res_count   = '0;
                end
            end
            rht_pkg::S_DONE: begin
                if (out_free) begin
                    n_out_vld    = 1'b1;
                    n_out_slot   = r_res_slot;
                    n_out_status = r_res_status;
                    n_out_count  = r_res_count;
                end
            end
            default: begin
                n_out_vld = r_out_vld && !i_m_axis_tready;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= rht_pkg::S_IDLE;
            r_cmp_vld  <= 1'b0;
            r_free_vld <= 1'b0;
            r_used     <= '0;
            r_out_vld  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_cmp_vld  <= n_cmp_vld;
            r_free_vld <= n_free_vld;
            r_used     <= n_used;
            r_out_vld  <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd        <= n_cmd;
        r_key        <= n_key;
        r_hdl        <= n_hdl;
        r_idx        <= n_idx;
        r_cmp_idx    <= n_cmp_idx;
        r_free_idx   <= n_free_idx;
        r_res_slot   <= n_res_slot;
        r_res_status <= n_res_status;
        r_res_count  <= n_res_count;
        r_out_slot   <= n_out_slot;
        r_out_status <= n_out_status;
        r_out_count  <= n_out_count;
    end

    // With more than sixteen slots only the low handle bits leave the block.
    assign slot_wide       = SW'(r_out_slot);
    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = {4'b0000, r_out_count, slot_wide[rht_pkg::HANDLE_W-1:0]};
    assign o_m_axis_tuser  = r_out_status;

    a_acquire_scans: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire && (in_cmd == rht_pkg::CMD_ACQUIRE) && (in_key != '0)
        |=> (r_state == rht_pkg::S_SCAN))
        else $error("nonzero-key acquire did not start a scan");

    a_write_ends_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we |=> (r_state == rht_pkg::S_DONE))
        else $error("table write outside the final step of a transaction");

    a_new_count_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && (r_out_status == rht_pkg::ST_NEW) |-> (r_out_count == CW'(1)))
        else $error("new handle reported with count other than one");

    a_error_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && ((r_out_status == rht_pkg::ST_FULL) || (r_out_status == rht_pkg::ST_NULL)
            || (r_out_status == rht_pkg::ST_RANGE) || (r_out_status == rht_pkg::ST_STALE))
        |-> (r_out_slot == '0) && (r_out_count == '0))
        else $error("error result carries a nonzero handle or count");

    a_shared_used: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        hit |-> (r_state == rht_pkg::S_SCAN) && (r_cmd == rht_pkg::CMD_ACQUIRE))
        else $error("key match outside an acquire scan");

endmodule

`default_nettype wire

/* sim/tb_refcounted_handle_table.sv */
`timescale 1ns / 1ps

module tb_refcounted_handle_table;

    localparam int SLOTS = 16;
    localparam int RANDOM_ITEMS = 950;
    localparam int POOL_SIZE = 24;
    localparam int LONG_HOLD = 400;
    localparam logic [7:0] FIRST_BAD_HANDLE = 8'(SLOTS);

    typedef struct packed {
        logic [rht_pkg::HANDLE_W-1:0] handle;
        rht_pkg::t_status             status;
        logic [rht_pkg::COUNT_W-1:0]  count;
    } t_handle_result;

    typedef struct packed {
        rht_pkg::t_cmd             cmd;
        logic [rht_pkg::KEY_W-1:0] key;
        logic [7:0]                hnd;
        bit                        typed;
        t_handle_result            res;
    } t_stim_row;

    typedef enum int {
        RX_OPEN,
        RX_RANDOM,
        RX_PULSED
    } t_rx_mode;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_axis_tvalid;
    logic        o_s_axis_tready;
    logic [39:0] i_s_axis_tdata;   // object_key [31:0], release_handle [39:32]
    logic        i_s_axis_tuser;   // cmd [0]
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready;
    logic [23:0] o_m_axis_tdata;   // handle_out [3:0], ref_count [19:4], zero pad
    logic [2:0]  o_m_axis_tuser;   // status [2:0]

    refcounted_handle_table #(
        .SLOTS(SLOTS)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s_axis_tvalid(i_s_axis_tvalid),
        .o_s_axis_tready(o_s_axis_tready),
        .i_s_axis_tdata (i_s_axis_tdata),
        .i_s_axis_tuser (i_s_axis_tuser),
        .o_m_axis_tvalid(o_m_axis_tvalid),
        .i_m_axis_tready(i_m_axis_tready),
        .o_m_axis_tdata (o_m_axis_tdata),
        .o_m_axis_tuser (o_m_axis_tuser)
    );

    // Shadow copy of the handle table.
    logic [rht_pkg::KEY_W-1:0]   model_key   [SLOTS];
    bit                          model_used  [SLOTS];
    logic [rht_pkg::COUNT_W-1:0] model_count [SLOTS];

    t_handle_result expected_results[$];
    t_stim_row      directed_rows[$];

    int n_fail = 0;
    int n_sent = 0;
    int n_checked = 0;
    int burst_left = 0;
    int status_seen [8];
    bit long_hold_go = 0;
    bit long_hold_done = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("tb_refcounted_handle_table NOT OK");
        $finish;
    end

    task automatic predict_handle_op(input rht_pkg::t_cmd cmd,
                                     input logic [rht_pkg::KEY_W-1:0] key,
                                     input logic [7:0] hnd, output t_handle_result r);
        int hit;
        int free_slot;
        r.handle = '0;
        r.status = rht_pkg::ST_NULL;
        r.count  = '0;
        if (cmd == rht_pkg::CMD_ACQUIRE) begin
            if (key == '0) begin
                r.status = rht_pkg::ST_NULL;
            end else begin
                hit = -1;
                free_slot = -1;
                for (int i = 0; i < SLOTS; i++) begin
                    if (hit < 0 && model_used[i] && model_key[i] == key) hit = i;
                    if (free_slot < 0 && !model_used[i]) free_slot = i;
                end
                if (hit >= 0) begin
                    if (model_count[hit] != rht_pkg::COUNT_MAX) begin
                        model_count[hit] = model_count[hit] + 1'b1;
                    end
                    r.handle = hit[rht_pkg::HANDLE_W-1:0];
                    r.status = rht_pkg::ST_SHARED;
                    r.count  = model_count[hit];
                end else if (free_slot >= 0) begin
                    model_used[free_slot]  = 1'b1;
                    model_key[free_slot]   = key;
                    model_count[free_slot] = rht_pkg::COUNT_W'(1);
                    r.handle = free_slot[rht_pkg::HANDLE_W-1:0];
                    r.status = rht_pkg::ST_NEW;
                    r.count  = rht_pkg::COUNT_W'(1);
                end else begin
                    r.status = rht_pkg::ST_FULL;
                end
            end
        end else if (hnd >= FIRST_BAD_HANDLE) begin
            r.status = rht_pkg::ST_RANGE;
        end else if (!model_used[hnd]) begin
            r.status = rht_pkg::ST_STALE;
        end else if (model_count[hnd] > 1) begin
            model_count[hnd] = model_count[hnd] - 1'b1;
            r.handle = hnd[rht_pkg::HANDLE_W-1:0];
            r.status = rht_pkg::ST_HELD;
            r.count  = model_count[hnd];
        end else begin
            model_count[hnd] = '0;
            model_used[hnd]  = 1'b0;
            r.handle = hnd[rht_pkg::HANDLE_W-1:0];
            r.status = rht_pkg::ST_FREED;
        end
    endtask

    task automatic add_row(input rht_pkg::t_cmd cmd, input logic [rht_pkg::KEY_W-1:0] key,
                           input logic [7:0] hnd, input bit typed, input int h,
                           input rht_pkg::t_status st, input int cnt);
        t_stim_row row;
        row.cmd = cmd;
        row.key = key;
        row.hnd = hnd;
        row.typed = typed;
        row.res.handle = h[rht_pkg::HANDLE_W-1:0];
        row.res.status = st;
        row.res.count  = cnt[rht_pkg::COUNT_W-1:0];
        directed_rows.push_back(row);
    endtask

    // Offers one transaction, waits for it to be taken, then records what the
    // table should answer. The valid line is only lowered when a gap follows.
    task automatic send_item(input rht_pkg::t_cmd cmd, input logic [rht_pkg::KEY_W-1:0] key,
                             input logic [7:0] hnd, input bit typed,
                             input t_handle_result typed_res);
        t_handle_result r;
        int gap;
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {hnd, key};
        i_s_axis_tuser  <= cmd;
        do @(posedge i_clk); while (!o_s_axis_tready);
        predict_handle_op(cmd, key, hnd, r);
        expected_results.push_back(typed ? typed_res : r);
        n_sent++;
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
            gap = $urandom_range(1, 12);
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 6);
        end
    endtask

    task automatic drain_results();
        i_s_axis_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
    endtask

    // Receiver: checks every result against the oldest expectation and
    // stalls on its own pattern.
    initial begin : rx_side
        t_handle_result got;
        t_handle_result want;
        t_rx_mode rx_mode;
        int hold_left;
        int mode_left;
        int tick;
        bit rdy;
        hold_left = 0;
        mode_left = 0;
        tick = 0;
        rx_mode = RX_OPEN;
        for (int i = 0; i < 8; i++) status_seen[i] = 0;
        i_m_axis_tready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
                got.handle = o_m_axis_tdata[3:0];
                got.count  = o_m_axis_tdata[19:4];
                got.status = rht_pkg::t_status'(o_m_axis_tuser);
                if (expected_results.size() == 0) begin
                    $error("result with nothing expected: handle %0d status %0d count %0d",
                           got.handle, got.status, got.count);
                    n_fail++;
                end else begin
                    want = expected_results.pop_front();
                    if (got.handle !== want.handle) begin
                        $error("handle_out: expected %0d, got %0d", want.handle, got.handle);
                        n_fail++;
                    end
                    if (got.status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, got.status);
                        n_fail++;
                    end
                    if (got.count !== want.count) begin
                        $error("ref_count: expected %0d, got %0d", want.count, got.count);
                        n_fail++;
                    end
                    status_seen[got.status]++;
                    n_checked++;
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                rdy = 1'b0;
            end else if (long_hold_go && !long_hold_done) begin
                long_hold_done = 1'b1;
                hold_left = LONG_HOLD - 1;
                rdy = 1'b0;
            end else begin
                if (mode_left == 0) begin
                    rx_mode = t_rx_mode'($urandom_range(0, 2));
                    mode_left = $urandom_range(10, 150);
                end
                mode_left--;
                tick++;
                case (rx_mode)
                    RX_OPEN:   rdy = 1'b1;
                    RX_RANDOM: rdy = ($urandom_range(0, 99) < 55);
                    default:   rdy = ((tick % 7) > 2);
                endcase
            end
            i_m_axis_tready <= rdy;
        end
    end

    initial begin : stim
        logic [rht_pkg::KEY_W-1:0] key_pool [POOL_SIZE];
        logic [rht_pkg::KEY_W-1:0] key;
        logic [7:0] hnd;
        t_stim_row row;
        t_handle_result none;
        int used_list [SLOTS];
        int n_used;
        int pick;
        none = '0;
        i_rst_n = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata = '0;
        i_s_axis_tuser = 1'b0;
        for (int i = 0; i < SLOTS; i++) begin
            model_key[i] = '0;
            model_used[i] = 1'b0;
            model_count[i] = '0;
        end
        for (int i = 0; i < POOL_SIZE; i++) begin
            key_pool[i] = $urandom;
            if (key_pool[i] == '0) key_pool[i] = 32'h1;
        end

        // Directed table. Rows with typed results come straight from a fresh
        // table; the fill rows are left to the predictor.
        add_row(rht_pkg::CMD_ACQUIRE, 32'h0, 8'hFF, 1'b1, 0, rht_pkg::ST_NULL, 0);
        add_row(rht_pkg::CMD_RELEASE, 32'hFFFF_FFFF, 8'h00, 1'b1, 0, rht_pkg::ST_STALE, 0);
        add_row(rht_pkg::CMD_RELEASE, 32'h0, 8'hFF, 1'b1, 0, rht_pkg::ST_RANGE, 0);
        add_row(rht_pkg::CMD_RELEASE, 32'h0, FIRST_BAD_HANDLE, 1'b1, 0, rht_pkg::ST_RANGE, 0);
        add_row(rht_pkg::CMD_ACQUIRE, 32'hFFFF_FFFF, 8'h00, 1'b1, 0, rht_pkg::ST_NEW, 1);
        add_row(rht_pkg::CMD_ACQUIRE, 32'hFFFF_FFFF, 8'hFF, 1'b1, 0, rht_pkg::ST_SHARED, 2);
        add_row(rht_pkg::CMD_ACQUIRE, 32'h1, 8'h00, 1'b1, 1, rht_pkg::ST_NEW, 1);
        add_row(rht_pkg::CMD_RELEASE, 32'h0, 8'h00, 1'b1, 0, rht_pkg::ST_HELD, 1);
        add_row(rht_pkg::CMD_RELEASE, 32'h0, 8'h00, 1'b1, 0, rht_pkg::ST_FREED, 0);
        add_row(rht_pkg::CMD_RELEASE, 32'h0, 8'h00, 1'b1, 0, rht_pkg::ST_STALE, 0);
        add_row(rht_pkg::CMD_ACQUIRE, 32'h8000_0000, 8'h00, 1'b1, 0, rht_pkg::ST_NEW, 1);
        for (int i = 2; i < SLOTS; i++) begin
            add_row(rht_pkg::CMD_ACQUIRE, 32'hA5C3_9600 | i, 8'h00, 1'b0, 0,
                    rht_pkg::ST_NEW, 0);
        end
        add_row(rht_pkg::CMD_ACQUIRE, 32'h1234_5678, 8'h00, 1'b1, 0, rht_pkg::ST_FULL, 0);
        add_row(rht_pkg::CMD_RELEASE, 32'h0, 8'(SLOTS - 1), 1'b0, 0, rht_pkg::ST_NEW, 0);

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[i]) begin
            row = directed_rows[i];
            send_item(row.cmd, row.key, row.hnd, row.typed, row.res);
        end
        drain_results();

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == 300) long_hold_go = 1'b1;
            if (n == 600) drain_results();
            pick = $urandom_range(0, 99);
            key = $urandom;
            hnd = 8'($urandom_range(0, 255));
            if (pick < 45) begin
                send_item(rht_pkg::CMD_ACQUIRE, key_pool[$urandom_range(0, POOL_SIZE - 1)],
                          hnd, 1'b0, none);
            end else if (pick < 53) begin
                send_item(rht_pkg::CMD_ACQUIRE, key, hnd, 1'b0, none);
            end else if (pick < 57) begin
                send_item(rht_pkg::CMD_ACQUIRE, '0, hnd, 1'b0, none);
            end else if (pick < 87) begin
                n_used = 0;
                for (int i = 0; i < SLOTS; i++) begin
                    if (model_used[i]) begin
                        used_list[n_used] = i;
                        n_used++;
                    end
                end
                if (n_used > 0) hnd = 8'(used_list[$urandom_range(0, n_used - 1)]);
                else hnd = 8'($urandom_range(0, SLOTS - 1));
                send_item(rht_pkg::CMD_RELEASE, key, hnd, 1'b0, none);
            end else if (pick < 93) begin
                send_item(rht_pkg::CMD_RELEASE, key, hnd, 1'b0, none);
            end else begin
                hnd = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(SLOTS, SLOTS + 3))
                                                   : 8'($urandom_range(0, SLOTS - 1));
                send_item(rht_pkg::CMD_RELEASE, key, hnd, 1'b0, none);
            end
        end
        drain_results();

        repeat (SLOTS + 8) @(posedge i_clk);
        if (expected_results.size() != 0) begin
            $error("%0d expected results never arrived", expected_results.size());
        end

        $display("Sent %0d items (%0d directed), checked %0d; long receiver hold %s.",
                 n_sent, directed_rows.size(), n_checked, long_hold_done ? "done" : "missed");
        $display("Status mix new/shared/full/null: %0d/%0d/%0d/%0d, ",
                 status_seen[0], status_seen[1], status_seen[2], status_seen[3],
                 "held/freed/range/stale: %0d/%0d/%0d/%0d.",
                 status_seen[4], status_seen[5], status_seen[6], status_seen[7]);
        if (n_fail == 0 && expected_results.size() == 0) begin
            $display("tb_refcounted_handle_table OK");
        end else begin
            $display("tb_refcounted_handle_table NOT OK");
        end
        $finish;
    end

endmodule

/* files.f */
src/rht_pkg.sv
src/rht_ram.sv
src/rht_unit.sv
src/refcounted_handle_table.sv
sim/tb_refcounted_handle_table.sv
